>>> rtl/multi_channel_tick_timer_assert.svh
// Assertion macros shared by the tick timer checker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef MULTI_CHANNEL_TICK_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_TICK_TIMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick timer check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick timer check failed");

`endif

>>> rtl/mtt_pkg.sv
// Types and constants for the multi-channel tick timer.
// Used by every module of the block; depends on nothing.
package mtt_pkg;

    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_REGISTER   = 2'd1;
    localparam logic [1:0] CMD_UNREGISTER = 2'd2;

    localparam int MAX_EVENTS = 8;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  timer_channel;
        logic [31:0] start_delay;
        logic [31:0] reload_period;
    } request_t;

    typedef struct packed {
        logic [2:0]  fired_channel;
        logic [31:0] fire_time;
        logic        last_of_tick;
    } result_t;

    typedef struct packed {
        logic        active;
        logic [31:0] tick_now;
    } scan_t;

    typedef struct packed {
        logic        arm;
        logic        disarm;
        logic [31:0] expiry;
        logic [31:0] period;
    } cell_ctrl_t;

endpackage

>>> rtl/mtt_cell.sv
// One timer channel cell: expiry, period and running flag, plus one scan stage.
// Depends on mtt_pkg.
module mtt_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  mtt_pkg::cell_ctrl_t ctrl,
    input  mtt_pkg::scan_t     scan_in,
    output mtt_pkg::scan_t     scan_out,
    output logic               fire
);

    logic [31:0]    expiry_reg;
    logic [31:0]    period_reg;
    logic           running_reg;
    mtt_pkg::scan_t scan_reg;

    assign fire     = scan_in.active && running_reg && (expiry_reg == scan_in.tick_now);
    assign scan_out = scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg  <= '0;
            period_reg  <= '0;
            running_reg <= 1'b0;
            scan_reg    <= '0;
        end
        else
        begin
            scan_reg <= scan_in;
            if (ctrl.arm)
            begin
                expiry_reg  <= ctrl.expiry;
                period_reg  <= ctrl.period;
                running_reg <= 1'b1;
            end
            else if (ctrl.disarm)
            begin
                running_reg <= 1'b0;
            end
            else if (fire)
            begin
                if (period_reg != 32'd0)
                begin
                    expiry_reg <= expiry_reg + period_reg;
                end
                else
                begin
                    running_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> rtl/multi_channel_tick_timer.sv
// A tick command advances the 32-bit tick time and sends a scan token down a row of
// CHANNELS cells, one cell per cycle, so busy stays high until the token has passed the
// last cell, and the next command is accepted only once busy drops. Every running
// channel whose expiry equals the new time produces one result beat, in ascending channel
// order, at most eight per tick; each beat shows for one cycle under result_valid and must
// be taken then. The last beat of a tick carries last_of_tick and appears as busy drops.
// Register and unregister commands finish in the cycle they are accepted and produce no
// beats. Depends on mtt_pkg and mtt_cell.
module multi_channel_tick_timer #(
    parameter int CHANNELS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mtt_pkg::request_t request,
    output logic              result_valid,
    output mtt_pkg::result_t  result
);

    mtt_pkg::scan_t             chain [CHANNELS+1];
    mtt_pkg::cell_ctrl_t        ctrl  [CHANNELS];
    logic [CHANNELS-1:0]        fire;
    logic                       fire_any;
    logic [2:0]                 fire_idx;
    logic                       accept;
    logic                       arm_ok;
    logic [31:0]                arm_expiry;

    logic [31:0]                tick_time_reg;
    mtt_pkg::scan_t             head_reg;
    logic                       busy_reg;
    logic [mtt_pkg::CNT_W-1:0]  event_cnt_reg;
    logic                       pend_valid_reg;
    logic [2:0]                 pend_idx_reg;
    logic                       result_valid_reg;
    mtt_pkg::result_t           result_reg;

    assign accept     = start && !busy_reg;
    assign arm_ok     = (request.start_delay != 32'd0) || (request.reload_period != 32'd0);
    assign arm_expiry = tick_time_reg + ((request.start_delay != 32'd0) ?
                        request.start_delay : request.reload_period);
    assign chain[0]   = head_reg;

    genvar k;
    generate
        for (k = 0; k < CHANNELS; k++)
        begin : g_cell
            always_comb
            begin
                ctrl[k].arm    = accept && (request.command == mtt_pkg::CMD_REGISTER) &&
                                 arm_ok && (32'(request.timer_channel) == k);
                ctrl[k].disarm = accept && (request.command == mtt_pkg::CMD_UNREGISTER) &&
                                 (32'(request.timer_channel) == k);
                ctrl[k].expiry = arm_expiry;
                ctrl[k].period = request.reload_period;
            end

            mtt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl[k]),
                .scan_in  (chain[k]),
                .scan_out (chain[k+1]),
                .fire     (fire[k])
            );
        end
    endgenerate

    always_comb
    begin
        fire_idx = 3'd0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (fire[i])
            begin
                fire_idx = fire_idx | 3'(i);
            end
        end
    end

    assign fire_any = |fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg    <= '0;
            head_reg         <= '0;
            busy_reg         <= 1'b0;
            event_cnt_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            pend_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            head_reg.active  <= 1'b0;
            result_valid_reg <= 1'b0;
            if (accept && (request.command == mtt_pkg::CMD_TICK))
            begin
                tick_time_reg     <= tick_time_reg + 32'd1;
                head_reg.active   <= 1'b1;
                head_reg.tick_now <= tick_time_reg + 32'd1;
                busy_reg          <= 1'b1;
                event_cnt_reg     <= '0;
                pend_valid_reg    <= 1'b0;
            end
            else if (chain[CHANNELS].active)
            begin
                busy_reg                <= 1'b0;
                pend_valid_reg          <= 1'b0;
                result_valid_reg        <= pend_valid_reg;
                result_reg.fired_channel <= pend_idx_reg;
                result_reg.fire_time    <= tick_time_reg;
                result_reg.last_of_tick <= 1'b1;
            end
            else if (fire_any && (event_cnt_reg < mtt_pkg::CNT_W'(mtt_pkg::MAX_EVENTS)))
            begin
                event_cnt_reg           <= event_cnt_reg + 1'b1;
                pend_valid_reg          <= 1'b1;
                pend_idx_reg            <= fire_idx;
                result_valid_reg        <= pend_valid_reg;
                result_reg.fired_channel <= pend_idx_reg;
                result_reg.fire_time    <= tick_time_reg;
                result_reg.last_of_tick <= 1'b0;
            end
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/mtt_checker.sv
// Port-level checks for the multi-channel tick timer, bound to the top level.
// Depends on mtt_pkg and multi_channel_tick_timer_assert.svh.
`include "multi_channel_tick_timer_assert.svh"

module mtt_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input mtt_pkg::request_t request,
    input logic              result_valid,
    input mtt_pkg::result_t  result
);

    `MTT_ASSERT_SAME(a_last_ends_tick, result_valid && result.last_of_tick, !busy)
    `MTT_ASSERT_SAME(a_mid_beat_busy, result_valid && !result.last_of_tick, busy)
    `MTT_ASSERT_NEXT(a_tick_sets_busy, start && !busy && (request.command == mtt_pkg::CMD_TICK), busy)
    `MTT_ASSERT_NEXT(a_other_is_quiet, start && !busy && (request.command != mtt_pkg::CMD_TICK), !busy && !result_valid)

endmodule

bind multi_channel_tick_timer mtt_checker u_mtt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

>>> tb/sv/multi_channel_tick_timer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_tick_timer: directed and random command beats.
// Depends on mtt_pkg and the multi_channel_tick_timer RTL.
module multi_channel_tick_timer_test;

    localparam int CHANNELS = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_COMMANDS = 300;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class tick_timer_scoreboard;
        logic [31:0]      now_tick;
        logic [31:0]      next_expiry [CHANNELS];
        logic [31:0]      reload [CHANNELS];
        logic             armed [CHANNELS];
        mtt_pkg::result_t expected_events [$];
        int               error_count;

        function new();
            now_tick = '0;
            error_count = 0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                next_expiry[k] = '0;
                reload[k] = '0;
                armed[k] = 1'b0;
            end
        endfunction

        function void note_request(mtt_pkg::request_t req);
            mtt_pkg::result_t batch [CHANNELS];
            int               fired;
            fired = 0;
            case (req.command)
                mtt_pkg::CMD_TICK:
                begin
                    now_tick = now_tick + 32'd1;
                    for (int k = 0; k < CHANNELS; k++)
                    begin
                        if (armed[k] && next_expiry[k] == now_tick)
                        begin
                            if (reload[k] != '0)
                                next_expiry[k] = next_expiry[k] + reload[k];
                            else
                                armed[k] = 1'b0;
                            if (fired < mtt_pkg::MAX_EVENTS)
                            begin
                                batch[fired].fired_channel = k[2:0];
                                batch[fired].fire_time = now_tick;
                                batch[fired].last_of_tick = 1'b0;
                                fired++;
                            end
                        end
                    end
                    if (fired > 0)
                        batch[fired - 1].last_of_tick = 1'b1;
                    for (int k = 0; k < fired; k++)
                        expected_events.push_back(batch[k]);
                end
                mtt_pkg::CMD_REGISTER:
                begin
                    if (req.start_delay != '0 || req.reload_period != '0)
                    begin
                        if (req.start_delay != '0)
                            next_expiry[req.timer_channel] = now_tick + req.start_delay;
                        else
                            next_expiry[req.timer_channel] = now_tick + req.reload_period;
                        reload[req.timer_channel] = req.reload_period;
                        armed[req.timer_channel] = 1'b1;
                    end
                end
                mtt_pkg::CMD_UNREGISTER:
                    armed[req.timer_channel] = 1'b0;
                default:
                    ;
            endcase
        endfunction

        function void check_result(mtt_pkg::result_t res);
            mtt_pkg::result_t want;
            if (expected_events.size() == 0)
            begin
                $error("unexpected result beat: channel %0d, time %0d",
                       res.fired_channel, res.fire_time);
                error_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (res.fired_channel !== want.fired_channel)
                begin
                    $error("fired_channel: expected %0d, actual %0d",
                           want.fired_channel, res.fired_channel);
                    error_count++;
                end
                if (res.fire_time !== want.fire_time)
                begin
                    $error("fire_time: expected %0d, actual %0d",
                           want.fire_time, res.fire_time);
                    error_count++;
                end
                if (res.last_of_tick !== want.last_of_tick)
                begin
                    $error("last_of_tick: expected %0d, actual %0d",
                           want.last_of_tick, res.last_of_tick);
                    error_count++;
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    mtt_pkg::request_t request;
    logic              result_valid;
    mtt_pkg::result_t  result;

    tick_timer_scoreboard sb;
    int  cycle_count;
    bit  gaps_on;

    multi_channel_tick_timer #(
        .CHANNELS (CHANNELS)
    )
    i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && start && !busy)
            sb.note_request(request);
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic mtt_pkg::request_t make_request(logic [1:0] cmd, logic [2:0] chan,
                                                       logic [31:0] delay,
                                                       logic [31:0] period);
        mtt_pkg::request_t req;
        req.command = cmd;
        req.timer_channel = chan;
        req.start_delay = delay;
        req.reload_period = period;
        return req;
    endfunction

    task automatic issue_command(mtt_pkg::request_t req);
        while (gaps_on && $urandom_range(99) < 13)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_delay();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(12);
        else if (roll < 90)
            return $urandom;
        return '0;
    endfunction

    function automatic logic [31:0] pick_period();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return '0;
        else if (roll < 85)
            return $urandom_range(10, 1);
        return $urandom;
    endfunction

    initial
    begin
        int roll;
        sb = new();
        cycle_count = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: ignored and one-shot registers, extreme values, all channels in one tick.
        issue_command(make_request(mtt_pkg::CMD_REGISTER, 3'd0, 32'd0, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_TICK, 3'd0, 32'd0, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_REGISTER, 3'd0, 32'd1, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_REGISTER, 3'd1, 32'd0, 32'd2));
        issue_command(make_request(mtt_pkg::CMD_REGISTER, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue_command(make_request(mtt_pkg::CMD_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue_command(make_request(mtt_pkg::CMD_UNREGISTER, 3'd5, 32'd0, 32'd0));
        issue_command(make_request(CMD_UNUSED, 3'd2, $urandom, $urandom));
        for (int k = 0; k < CHANNELS; k++)
            issue_command(make_request(mtt_pkg::CMD_REGISTER, k[2:0], 32'd2, 32'd1));
        issue_command(make_request(mtt_pkg::CMD_TICK, 3'd0, 32'd0, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_TICK, 3'd0, 32'd0, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_REGISTER, 3'd3, 32'd5, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_UNREGISTER, 3'd2, 32'd0, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_REGISTER, 3'd4, 32'd0, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_TICK, 3'd0, 32'd0, 32'd0));
        issue_command(make_request(mtt_pkg::CMD_TICK, 3'd0, 32'd0, 32'd0));

        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            gaps_on = (n < 100 || n >= 200);
            roll = $urandom_range(99);
            if (roll < 55)
                issue_command(make_request(mtt_pkg::CMD_TICK, 3'($urandom),
                                           $urandom, $urandom));
            else if (roll < 80)
                issue_command(make_request(mtt_pkg::CMD_REGISTER, 3'($urandom),
                                           pick_delay(), pick_period()));
            else if (roll < 93)
                issue_command(make_request(mtt_pkg::CMD_UNREGISTER, 3'($urandom),
                                           $urandom, $urandom));
            else
                issue_command(make_request(CMD_UNUSED, 3'($urandom), $urandom, $urandom));
        end
        start <= 1'b0;

        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (CHANNELS + 4) @(posedge clk);
        if (sb.error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
